@@ rtl/core/sfr_pkg.sv @@
package sfr_pkg;

    localparam int BYTE_W       = 8;
    localparam int WORD_W       = 16;
    localparam int CFG_IDX_W    = 3;

    // Header bytes plus CRC plus tail bytes around the unit body.
    localparam int FRAME_OVERHEAD = 9;
    localparam int BODY_OFFSET    = 5;
    localparam int UNIT_BYTES     = 3;
    localparam int RESULT_LIMIT   = 64;
    localparam int PROD_W         = 7;

    localparam logic [CFG_IDX_W-1:0] REG_HEAD_FIRST       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEAD_SECOND      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TAIL_LAST        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TAIL_BEFORE_LAST = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KNOWN_CODE_COUNT = 3'd4;

    localparam logic [BYTE_W-1:0] HEAD_FIRST_RST       = 8'h55;
    localparam logic [BYTE_W-1:0] HEAD_SECOND_RST      = 8'h5a;
    localparam logic [BYTE_W-1:0] TAIL_LAST_RST        = 8'haa;
    localparam logic [BYTE_W-1:0] TAIL_BEFORE_LAST_RST = 8'hbb;
    localparam logic [BYTE_W-1:0] KNOWN_CODE_COUNT_RST = 8'd82;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_OUTER,
        ST_SEARCH,
        ST_HEAD0,
        ST_HEAD1,
        ST_COUNT,
        ST_TAIL1,
        ST_TAIL2,
        ST_CRC,
        ST_CRC_DONE,
        ST_SERIAL0,
        ST_SERIAL1,
        ST_UNIT0,
        ST_UNIT1,
        ST_UNIT2,
        ST_EMIT
    } state_t;

    // One byte of CRC-16/XMODEM, polynomial 0x1021, table-free form.
    function automatic logic [WORD_W-1:0] crc16_step(logic [WORD_W-1:0] crc,
                                                     logic [BYTE_W-1:0] din);
        logic [BYTE_W-1:0] x;
        x = crc[15:8] ^ din;
        x = x ^ (x >> 4);
        return (crc << 8) ^ ({8'h00, x} << 12) ^ ({8'h00, x} << 5) ^ {8'h00, x};
    endfunction

endpackage

@@ rtl/core/sfr_if.sv @@
interface sfr_rx_if;
    logic                        valid;
    logic                        ready;
    logic [sfr_pkg::BYTE_W-1:0]  rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface sfr_res_if;
    logic                        valid;
    logic                        ready;
    logic [sfr_pkg::BYTE_W-1:0]  msg_code;
    logic [sfr_pkg::WORD_W-1:0]  unit_value;
    logic [sfr_pkg::WORD_W-1:0]  frame_serial;
    logic                        code_known;
    logic                        last_of_frame;

    modport source (output valid, output msg_code, output unit_value,
                    output frame_serial, output code_known, output last_of_frame,
                    input ready);
    modport sink (input valid, input msg_code, input unit_value,
                  input frame_serial, input code_known, input last_of_frame,
                  output ready);
endinterface

interface sfr_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [sfr_pkg::CFG_IDX_W-1:0] index;
    logic [sfr_pkg::BYTE_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/serial_frame_receiver_crc16.sv @@
// Channel  Direction  Payload
// rx       in         rx_byte
// res      out        msg_code, unit_value, frame_serial, code_known, last_of_frame
// cfg      in         index, data (register write, always ready)
//
// One byte is taken per transaction on rx, then the sequencer scans the ring memory
// through its single read port, one byte per cycle while no result waits on res. A byte
// is dropped on a bad head byte, an oversized count, a bad tail or a bad CRC, and the
// scan restarts. The CRC is run over the unit bytes and the CRC bytes, and each unit
// then waits for the res transaction. rx is ready only when the scan is idle. Reset
// clears pointers, state and the result count and loads the configuration defaults;
// the other registers and the ring memory itself are not cleared.
module serial_frame_receiver_crc16 #(
    parameter int QUEUE_DEPTH = 128,
    parameter int MAX_UNITS   = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    sfr_rx_if.sink     rx,
    sfr_res_if.source  res,
    sfr_cfg_if.sink    cfg
);

    localparam int AW       = $clog2(QUEUE_DEPTH);
    localparam int NEED_MAX = MAX_UNITS * sfr_pkg::UNIT_BYTES + sfr_pkg::FRAME_OVERHEAD;
    localparam int NW       = $clog2(NEED_MAX + 1);
    localparam int CW       = ((AW > NW) ? AW : NW) + 1;
    localparam int UW       = $clog2(MAX_UNITS + 1);
    localparam logic [AW:0] DEPTH_W = (AW+1)'(QUEUE_DEPTH);

    function automatic logic [AW-1:0] ring_add(logic [AW-1:0] a, logic [AW-1:0] b);
        logic [AW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= DEPTH_W)
        begin
            s = s - DEPTH_W;
        end
        return s[AW-1:0];
    endfunction

    logic [sfr_pkg::BYTE_W-1:0] ring_mem [QUEUE_DEPTH];

    sfr_pkg::state_t state_reg, state_next;

    logic [AW-1:0]              rp_reg, rp_next;
    logic [AW-1:0]              wp_reg, wp_next;
    logic [AW-1:0]              ofs_reg, ofs_next;
    logic [AW-1:0]              need_reg, need_next;
    logic [UW-1:0]              cnt_reg, cnt_next;
    logic [UW-1:0]              unit_reg, unit_next;
    logic [sfr_pkg::WORD_W-1:0] crc_reg, crc_next;
    logic [sfr_pkg::PROD_W-1:0] prod_reg, prod_next;
    logic [sfr_pkg::WORD_W-1:0] serial_reg, serial_next;
    logic [sfr_pkg::BYTE_W-1:0] code_reg, code_next;
    logic [sfr_pkg::BYTE_W-1:0] vhi_reg, vhi_next;
    logic [sfr_pkg::BYTE_W-1:0] rd_data_reg;

    logic [sfr_pkg::BYTE_W-1:0] out_code_reg, out_code_next;
    logic [sfr_pkg::WORD_W-1:0] out_value_reg, out_value_next;
    logic [sfr_pkg::WORD_W-1:0] out_serial_reg, out_serial_next;
    logic                       out_known_reg, out_known_next;
    logic                       out_last_reg, out_last_next;

    logic [sfr_pkg::BYTE_W-1:0] head_first_reg, head_second_reg;
    logic [sfr_pkg::BYTE_W-1:0] tail_last_reg, tail_before_last_reg, known_reg;

    logic [AW-1:0] fill;
    logic [AW-1:0] wp_inc;
    logic [AW-1:0] rd_ofs;
    logic [AW-1:0] rd_addr;
    logic [CW-1:0] need_w;
    logic          mem_we;
    logic          rx_hs;
    logic          out_hs;
    logic          fill_gt;
    logic          fill_ge;
    logic          cnt_bad;
    logic          need_short;
    logic          crc_last;
    logic          limit_hit;
    logic          unit_last;
    logic [sfr_pkg::WORD_W-1:0] crc_step;

    always_comb
    begin
        if (wp_reg >= rp_reg)
        begin
            fill = wp_reg - rp_reg;
        end
        else
        begin
            fill = AW'(({1'b0, wp_reg} + DEPTH_W) - {1'b0, rp_reg});
        end
    end

    assign wp_inc     = ring_add(wp_reg, AW'(1));
    assign rx_hs      = rx.valid && rx.ready;
    assign out_hs     = res.valid && res.ready;
    assign fill_gt    = CW'(fill) > CW'(sfr_pkg::FRAME_OVERHEAD);
    assign fill_ge    = CW'(fill) >= CW'(sfr_pkg::FRAME_OVERHEAD);
    assign cnt_bad    = rd_data_reg > sfr_pkg::BYTE_W'(MAX_UNITS);
    assign need_w     = CW'(rd_data_reg[UW-1:0]) * CW'(sfr_pkg::UNIT_BYTES)
                        + CW'(sfr_pkg::FRAME_OVERHEAD);
    assign need_short = need_w > CW'(fill);
    assign crc_step   = sfr_pkg::crc16_step(crc_reg, rd_data_reg);
    assign crc_last   = ofs_reg == (need_reg - AW'(3));
    assign limit_hit  = ({1'b0, prod_reg} + (sfr_pkg::PROD_W+1)'(cnt_reg))
                        > (sfr_pkg::PROD_W+1)'(sfr_pkg::RESULT_LIMIT);
    assign unit_last  = ({1'b0, unit_reg} + (UW+1)'(1)) == {1'b0, cnt_reg};
    assign rd_addr    = ring_add(rp_reg, rd_ofs);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sfr_pkg::ST_IDLE:     if (rx.valid) state_next = sfr_pkg::ST_OUTER;
            sfr_pkg::ST_OUTER:    state_next = fill_gt ? sfr_pkg::ST_SEARCH : sfr_pkg::ST_IDLE;
            sfr_pkg::ST_SEARCH:   state_next = fill_ge ? sfr_pkg::ST_HEAD0 : sfr_pkg::ST_IDLE;
            sfr_pkg::ST_HEAD0:
                state_next = (rd_data_reg == head_first_reg) ? sfr_pkg::ST_HEAD1
                                                             : sfr_pkg::ST_SEARCH;
            sfr_pkg::ST_HEAD1:
                state_next = (rd_data_reg == head_second_reg) ? sfr_pkg::ST_COUNT
                                                              : sfr_pkg::ST_SEARCH;
            sfr_pkg::ST_COUNT:
            begin
                priority if (cnt_bad)
                    state_next = sfr_pkg::ST_OUTER;
                else if (need_short)
                    state_next = sfr_pkg::ST_IDLE;
                else
                    state_next = sfr_pkg::ST_TAIL1;
            end
            sfr_pkg::ST_TAIL1:
                state_next = (rd_data_reg == tail_last_reg) ? sfr_pkg::ST_TAIL2
                                                            : sfr_pkg::ST_OUTER;
            sfr_pkg::ST_TAIL2:
                state_next = (rd_data_reg == tail_before_last_reg) ? sfr_pkg::ST_CRC
                                                                   : sfr_pkg::ST_OUTER;
            sfr_pkg::ST_CRC:      if (crc_last) state_next = sfr_pkg::ST_CRC_DONE;
            sfr_pkg::ST_CRC_DONE:
            begin
                priority if (crc_reg != '0)
                    state_next = sfr_pkg::ST_OUTER;
                else if (cnt_reg == '0)
                    state_next = sfr_pkg::ST_OUTER;
                else if (limit_hit)
                    state_next = sfr_pkg::ST_IDLE;
                else
                    state_next = sfr_pkg::ST_SERIAL0;
            end
            sfr_pkg::ST_SERIAL0:  state_next = sfr_pkg::ST_SERIAL1;
            sfr_pkg::ST_SERIAL1:  state_next = sfr_pkg::ST_UNIT0;
            sfr_pkg::ST_UNIT0:    state_next = sfr_pkg::ST_UNIT1;
            sfr_pkg::ST_UNIT1:    state_next = sfr_pkg::ST_UNIT2;
            sfr_pkg::ST_UNIT2:    state_next = sfr_pkg::ST_EMIT;
            sfr_pkg::ST_EMIT:
                if (out_hs) state_next = unit_last ? sfr_pkg::ST_OUTER : sfr_pkg::ST_UNIT0;
            default:              state_next = sfr_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        rx.ready        = (state_reg == sfr_pkg::ST_IDLE);
        res.valid       = (state_reg == sfr_pkg::ST_EMIT);
        cfg.ready       = 1'b1;
        mem_we          = 1'b0;
        rd_ofs          = '0;
        rp_next         = rp_reg;
        wp_next         = wp_reg;
        ofs_next        = ofs_reg;
        need_next       = need_reg;
        cnt_next        = cnt_reg;
        unit_next       = unit_reg;
        crc_next        = crc_reg;
        prod_next       = prod_reg;
        serial_next     = serial_reg;
        code_next       = code_reg;
        vhi_next        = vhi_reg;
        out_code_next   = out_code_reg;
        out_value_next  = out_value_reg;
        out_serial_next = out_serial_reg;
        out_known_next  = out_known_reg;
        out_last_next   = out_last_reg;

        unique case (state_reg)
            sfr_pkg::ST_IDLE:
            begin
                if (rx_hs)
                begin
                    mem_we    = 1'b1;
                    wp_next   = wp_inc;
                    prod_next = '0;
                    // A full ring loses its oldest byte to make room.
                    if (wp_inc == rp_reg)
                    begin
                        rp_next = ring_add(rp_reg, AW'(1));
                    end
                end
            end
            sfr_pkg::ST_OUTER:
            begin
            end
            sfr_pkg::ST_SEARCH:
            begin
                rd_ofs = '0;
            end
            sfr_pkg::ST_HEAD0:
            begin
                rd_ofs = AW'(1);
                if (rd_data_reg != head_first_reg)
                begin
                    rp_next = ring_add(rp_reg, AW'(1));
                end
            end
            sfr_pkg::ST_HEAD1:
            begin
                rd_ofs = AW'(2);
                if (rd_data_reg != head_second_reg)
                begin
                    rp_next = ring_add(rp_reg, AW'(1));
                end
            end
            sfr_pkg::ST_COUNT:
            begin
                rd_ofs    = AW'(need_w - CW'(1));
                need_next = AW'(need_w);
                cnt_next  = rd_data_reg[UW-1:0];
                if (cnt_bad)
                begin
                    rp_next = ring_add(rp_reg, AW'(1));
                end
            end
            sfr_pkg::ST_TAIL1:
            begin
                rd_ofs = need_reg - AW'(2);
                if (rd_data_reg != tail_last_reg)
                begin
                    rp_next = ring_add(rp_reg, AW'(1));
                end
            end
            sfr_pkg::ST_TAIL2:
            begin
                rd_ofs   = AW'(sfr_pkg::BODY_OFFSET);
                ofs_next = AW'(sfr_pkg::BODY_OFFSET);
                crc_next = '0;
                if (rd_data_reg != tail_before_last_reg)
                begin
                    rp_next = ring_add(rp_reg, AW'(1));
                end
            end
            sfr_pkg::ST_CRC:
            begin
                rd_ofs   = ofs_reg + AW'(1);
                ofs_next = ofs_reg + AW'(1);
                crc_next = crc_step;
            end
            sfr_pkg::ST_CRC_DONE:
            begin
                rd_ofs = AW'(3);
                priority if (crc_reg != '0)
                    rp_next = ring_add(rp_reg, AW'(1));
                else if (cnt_reg == '0)
                    rp_next = ring_add(rp_reg, need_reg);
                else
                    rp_next = rp_reg;
            end
            sfr_pkg::ST_SERIAL0:
            begin
                rd_ofs      = AW'(4);
                serial_next = {rd_data_reg, serial_reg[7:0]};
            end
            sfr_pkg::ST_SERIAL1:
            begin
                rd_ofs      = AW'(sfr_pkg::BODY_OFFSET);
                ofs_next    = AW'(sfr_pkg::BODY_OFFSET);
                unit_next   = '0;
                serial_next = {serial_reg[15:8], rd_data_reg};
            end
            sfr_pkg::ST_UNIT0:
            begin
                rd_ofs    = ofs_reg + AW'(1);
                code_next = rd_data_reg;
            end
            sfr_pkg::ST_UNIT1:
            begin
                rd_ofs   = ofs_reg + AW'(2);
                vhi_next = rd_data_reg;
            end
            sfr_pkg::ST_UNIT2:
            begin
                out_code_next   = code_reg;
                out_value_next  = {vhi_reg, rd_data_reg};
                out_serial_next = serial_reg;
                out_known_next  = code_reg < known_reg;
                out_last_next   = unit_last;
            end
            sfr_pkg::ST_EMIT:
            begin
                rd_ofs = ofs_reg + AW'(sfr_pkg::UNIT_BYTES);
                if (out_hs)
                begin
                    prod_next = prod_reg + sfr_pkg::PROD_W'(1);
                    ofs_next  = ofs_reg + AW'(sfr_pkg::UNIT_BYTES);
                    unit_next = unit_reg + UW'(1);
                    if (unit_last)
                    begin
                        rp_next = ring_add(rp_reg, need_reg);
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    assign res.msg_code      = out_code_reg;
    assign res.unit_value    = out_value_reg;
    assign res.frame_serial  = out_serial_reg;
    assign res.code_known    = out_known_reg;
    assign res.last_of_frame = out_last_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ring_mem[wp_reg] <= rx.rx_byte;
        end
        rd_data_reg <= ring_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sfr_pkg::ST_IDLE;
            rp_reg    <= '0;
            wp_reg    <= '0;
            prod_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            rp_reg    <= rp_next;
            wp_reg    <= wp_next;
            prod_reg  <= prod_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ofs_reg        <= ofs_next;
        need_reg       <= need_next;
        cnt_reg        <= cnt_next;
        unit_reg       <= unit_next;
        crc_reg        <= crc_next;
        serial_reg     <= serial_next;
        code_reg       <= code_next;
        vhi_reg        <= vhi_next;
        out_code_reg   <= out_code_next;
        out_value_reg  <= out_value_next;
        out_serial_reg <= out_serial_next;
        out_known_reg  <= out_known_next;
        out_last_reg   <= out_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_first_reg       <= sfr_pkg::HEAD_FIRST_RST;
            head_second_reg      <= sfr_pkg::HEAD_SECOND_RST;
            tail_last_reg        <= sfr_pkg::TAIL_LAST_RST;
            tail_before_last_reg <= sfr_pkg::TAIL_BEFORE_LAST_RST;
            known_reg            <= sfr_pkg::KNOWN_CODE_COUNT_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                sfr_pkg::REG_HEAD_FIRST:       head_first_reg       <= cfg.data;
                sfr_pkg::REG_HEAD_SECOND:      head_second_reg      <= cfg.data;
                sfr_pkg::REG_TAIL_LAST:        tail_last_reg        <= cfg.data;
                sfr_pkg::REG_TAIL_BEFORE_LAST: tail_before_last_reg <= cfg.data;
                sfr_pkg::REG_KNOWN_CODE_COUNT: known_reg            <= cfg.data;
                default:
                begin
                end
            endcase
        end
    end

endmodule

@@ rtl/core/sfr_checker.sv @@
module sfr_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        rx_ready,
    input logic                        res_valid,
    input logic                        res_ready,
    input logic                        res_last,
    input logic [sfr_pkg::BYTE_W-1:0]  res_code,
    input logic [sfr_pkg::WORD_W-1:0]  res_value,
    input logic [sfr_pkg::WORD_W-1:0]  res_serial
);

    // A pending result is held until its transaction completes.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result valid dropped before transaction");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(res_code) && $stable(res_value)
                                    && $stable(res_serial) && $stable(res_last))
        else $error("result payload changed while stalled");

    // Input bytes are never taken while a result is being offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(rx_ready && res_valid))
        else $error("input ready while a result is pending");

    // After a unit that is not the last of its frame, the frame is still being read out.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready && !res_last |=> !rx_ready)
        else $error("input ready in the middle of a frame");

endmodule

bind serial_frame_receiver_crc16 sfr_checker u_sfr_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .rx_ready   (rx.ready),
    .res_valid  (res.valid),
    .res_ready  (res.ready),
    .res_last   (res.last_of_frame),
    .res_code   (res.msg_code),
    .res_value  (res.unit_value),
    .res_serial (res.frame_serial)
);

@@ tb/tb_serial_frame_receiver_crc16.sv @@
`timescale 1ns / 1ps

module tb_serial_frame_receiver_crc16;

    localparam int RING_DEPTH = 128;
    localparam int UNIT_MAX   = 16;
    localparam int DRAIN_WAIT = 1000;

    typedef enum int {FR_GOOD, FR_BAD_CRC, FR_BAD_TAIL, FR_OVERSIZE, FR_TRUNC, FR_NOISE} frame_kind_t;

    typedef struct packed {
        logic [sfr_pkg::BYTE_W-1:0] code;
        logic [sfr_pkg::WORD_W-1:0] value;
        logic [sfr_pkg::WORD_W-1:0] serial;
        logic                       known;
        logic                       last;
    } unit_res_t;

    typedef struct {
        frame_kind_t                kind;
        int                         units;
        logic [sfr_pkg::WORD_W-1:0] serial;
        logic [sfr_pkg::BYTE_W-1:0] code;
        logic [sfr_pkg::WORD_W-1:0] value;
        int                         exp_units;
    } frame_row_t;

    logic clk;
    logic rst_n;

    sfr_rx_if  rx();
    sfr_res_if res();
    sfr_cfg_if cfg();

    serial_frame_receiver_crc16 u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx),
        .res   (res),
        .cfg   (cfg)
    );

    // Shadow of the block's ring and registers.
    logic [sfr_pkg::BYTE_W-1:0] shadow_ring [RING_DEPTH];
    int                         rd_ptr;
    int                         wr_ptr;
    logic [sfr_pkg::BYTE_W-1:0] cfg_regs [5];

    unit_res_t expected_units[$];
    int        units_predicted;
    int        error_count;
    int        idle_mode;
    logic      hold_res;

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    initial
    begin
        #3000000;
        $display("FAILURE");
        $finish;
    end

    task automatic report(input string what);
        $display("ERROR %0t: %s", $realtime, what);
        error_count++;
    endtask

    function automatic int ring_fill();
        return (wr_ptr + RING_DEPTH - rd_ptr) % RING_DEPTH;
    endfunction

    function automatic logic [sfr_pkg::BYTE_W-1:0] ring_at(input int offset);
        return shadow_ring[(rd_ptr + offset) % RING_DEPTH];
    endfunction

    function automatic logic [sfr_pkg::WORD_W-1:0] crc_xmodem(
        input logic [sfr_pkg::WORD_W-1:0] crc,
        input logic [sfr_pkg::BYTE_W-1:0] b);
        logic [sfr_pkg::WORD_W-1:0] x;
        x = {8'h00, crc[15:8] ^ b};
        x = x ^ (x >> 4);
        return (crc << 8) ^ (x << 12) ^ (x << 5) ^ x;
    endfunction

    // Appends one byte and scans the buffer for complete frames.
    task automatic predict_frames(input logic [sfr_pkg::BYTE_W-1:0] b);
        int produced;
        int cnt;
        int need;
        int base;
        logic found;
        logic [sfr_pkg::WORD_W-1:0] crc;
        logic [sfr_pkg::WORD_W-1:0] serial;
        unit_res_t u;
        produced = 0;
        if ((wr_ptr + 1) % RING_DEPTH == rd_ptr)
            rd_ptr = (rd_ptr + 1) % RING_DEPTH;
        shadow_ring[wr_ptr] = b;
        wr_ptr = (wr_ptr + 1) % RING_DEPTH;
        while (ring_fill() > sfr_pkg::FRAME_OVERHEAD)
        begin
            found = 1'b0;
            while (ring_fill() >= sfr_pkg::FRAME_OVERHEAD)
            begin
                if (ring_at(0) == cfg_regs[sfr_pkg::REG_HEAD_FIRST] &&
                    ring_at(1) == cfg_regs[sfr_pkg::REG_HEAD_SECOND])
                begin
                    found = 1'b1;
                    break;
                end
                rd_ptr = (rd_ptr + 1) % RING_DEPTH;
            end
            if (!found)
                break;
            cnt = int'(ring_at(2));
            if (cnt > UNIT_MAX)
            begin
                rd_ptr = (rd_ptr + 1) % RING_DEPTH;
                continue;
            end
            need = cnt * sfr_pkg::UNIT_BYTES + sfr_pkg::FRAME_OVERHEAD;
            if (need > ring_fill())
                break;
            if (ring_at(need - 1) != cfg_regs[sfr_pkg::REG_TAIL_LAST] ||
                ring_at(need - 2) != cfg_regs[sfr_pkg::REG_TAIL_BEFORE_LAST])
            begin
                rd_ptr = (rd_ptr + 1) % RING_DEPTH;
                continue;
            end
            crc = '0;
            for (int i = 0; i < cnt * sfr_pkg::UNIT_BYTES + 2; i++)
                crc = crc_xmodem(crc, ring_at(sfr_pkg::BODY_OFFSET + i));
            if (crc != 0)
            begin
                rd_ptr = (rd_ptr + 1) % RING_DEPTH;
                continue;
            end
            if (produced + cnt > sfr_pkg::RESULT_LIMIT)
                break;
            serial = {ring_at(3), ring_at(4)};
            for (int i = 0; i < cnt; i++)
            begin
                base = sfr_pkg::BODY_OFFSET + i * sfr_pkg::UNIT_BYTES;
                u.code   = ring_at(base);
                u.value  = {ring_at(base + 1), ring_at(base + 2)};
                u.serial = serial;
                u.known  = u.code < cfg_regs[sfr_pkg::REG_KNOWN_CODE_COUNT];
                u.last   = (i + 1 == cnt);
                expected_units.push_back(u);
                produced++;
            end
            rd_ptr = (rd_ptr + need) % RING_DEPTH;
        end
        units_predicted += produced;
    endtask

    task automatic send_byte(input logic [sfr_pkg::BYTE_W-1:0] b);
        while ((idle_mode == 1 || idle_mode == 2) ? ($urandom_range(99) < 63) :
               (idle_mode == 3) ? ($urandom_range(99) < 11) : 1'b0)
        begin
            if (idle_mode == 2)
                break;
            rx.valid <= 1'b0;
            @(negedge clk);
        end
        rx.valid   <= 1'b1;
        rx.rx_byte <= b;
        do
            @(posedge clk);
        while (!rx.ready);
        predict_frames(b);
        @(negedge clk);
    endtask

    task automatic send_frame(input frame_kind_t kind, input int units,
                              input logic [sfr_pkg::WORD_W-1:0] serial, input logic fixed,
                              input logic [sfr_pkg::BYTE_W-1:0] code,
                              input logic [sfr_pkg::WORD_W-1:0] value);
        logic [sfr_pkg::BYTE_W-1:0] fb[$];
        logic [sfr_pkg::WORD_W-1:0] crc;
        int stop;
        fb = {};
        if (kind == FR_NOISE)
        begin
            repeat ($urandom_range(1, 6))
                fb.push_back(sfr_pkg::BYTE_W'($urandom_range(255)));
        end
        else
        begin
            fb.push_back(cfg_regs[sfr_pkg::REG_HEAD_FIRST]);
            fb.push_back(cfg_regs[sfr_pkg::REG_HEAD_SECOND]);
            if (kind == FR_OVERSIZE)
            begin
                fb.push_back(fixed ? 8'd17
                                   : sfr_pkg::BYTE_W'($urandom_range(UNIT_MAX + 1, 255)));
                repeat (5)
                    fb.push_back(sfr_pkg::BYTE_W'($urandom_range(255)));
            end
            else
            begin
                fb.push_back(sfr_pkg::BYTE_W'(units));
                fb.push_back(serial[15:8]);
                fb.push_back(serial[7:0]);
                crc = '0;
                for (int i = 0; i < units; i++)
                begin
                    logic [sfr_pkg::BYTE_W-1:0] c;
                    logic [sfr_pkg::WORD_W-1:0] v;
                    c = fixed ? code : sfr_pkg::BYTE_W'($urandom_range(255));
                    v = fixed ? value : sfr_pkg::WORD_W'($urandom_range(65535));
                    fb.push_back(c);
                    fb.push_back(v[15:8]);
                    fb.push_back(v[7:0]);
                    crc = crc_xmodem(crc_xmodem(crc_xmodem(crc, c), v[15:8]), v[7:0]);
                end
                if (kind == FR_BAD_CRC)
                    crc ^= fixed ? 16'h0001 : 16'($urandom_range(1, 65535));
                fb.push_back(crc[15:8]);
                fb.push_back(crc[7:0]);
                fb.push_back(cfg_regs[sfr_pkg::REG_TAIL_BEFORE_LAST]);
                fb.push_back(kind == FR_BAD_TAIL ? ~cfg_regs[sfr_pkg::REG_TAIL_LAST]
                                                 : cfg_regs[sfr_pkg::REG_TAIL_LAST]);
            end
        end
        stop = (kind == FR_TRUNC) ? $urandom_range(3, fb.size() - 1) : fb.size();
        for (int i = 0; i < stop; i++)
            send_byte(fb[i]);
    endtask

    task automatic write_reg(input logic [sfr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [sfr_pkg::BYTE_W-1:0] val);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val;
        do
            @(posedge clk);
        while (!cfg.ready);
        cfg_regs[idx] = val;
        @(negedge clk);
        cfg.valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic drain();
        rx.valid <= 1'b0;
        while (expected_units.size() != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT)
            @(negedge clk);
    endtask

    task automatic random_traffic(input int byte_budget);
        int pick;
        int units;
        frame_kind_t kind;
        for (int sent = 0; sent < byte_budget; )
        begin
            pick  = $urandom_range(99);
            kind  = pick < 60 ? FR_GOOD : pick < 68 ? FR_BAD_CRC : pick < 74 ? FR_BAD_TAIL :
                    pick < 80 ? FR_OVERSIZE : pick < 85 ? FR_TRUNC : FR_NOISE;
            units = ($urandom_range(9) == 0) ? $urandom_range(UNIT_MAX) : $urandom_range(4);
            send_frame(kind, units, sfr_pkg::WORD_W'($urandom_range(65535)), 1'b0, '0, '0);
            sent += units * sfr_pkg::UNIT_BYTES + sfr_pkg::FRAME_OVERHEAD;
        end
    endtask

    // Results are checked in order at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n && res.valid && res.ready)
        begin
            if (expected_units.size() == 0)
                report($sformatf("unexpected unit code %0h", res.msg_code));
            else
            begin
                unit_res_t e;
                e = expected_units.pop_front();
                if (res.msg_code !== e.code)
                    report($sformatf("msg_code %0h, want %0h", res.msg_code, e.code));
                if (res.unit_value !== e.value)
                    report($sformatf("unit_value %0h, want %0h", res.unit_value, e.value));
                if (res.frame_serial !== e.serial)
                    report($sformatf("frame_serial %0h, want %0h", res.frame_serial, e.serial));
                if (res.code_known !== e.known)
                    report($sformatf("code_known %0b, want %0b", res.code_known, e.known));
                if (res.last_of_frame !== e.last)
                    report($sformatf("last_of_frame %0b, want %0b", res.last_of_frame, e.last));
            end
        end
    end

    always @(negedge clk)
    begin
        if (hold_res)
            res.ready <= 1'b0;
        else if (idle_mode == 2)
            res.ready <= $urandom_range(99) >= 63;
        else if (idle_mode == 3)
            res.ready <= $urandom_range(99) >= 11;
        else
            res.ready <= 1'b1;
    end

    initial
    begin
        frame_row_t rows[$];
        int units_before;
        rows = '{
            '{FR_GOOD,     1,        16'h0000, 8'h00, 16'h0000, 1},
            '{FR_GOOD,     1,        16'hffff, 8'hff, 16'hffff, 1},
            '{FR_GOOD,     2,        16'h1234, 8'd81, 16'h00ff, 2},
            '{FR_GOOD,     2,        16'h8001, 8'd82, 16'hff00, 2},
            '{FR_GOOD,     0,        16'h0042, 8'h00, 16'h0000, 0},
            '{FR_GOOD,     UNIT_MAX, 16'ha5a5, 8'h10, 16'h5aa5, UNIT_MAX},
            '{FR_OVERSIZE, 0,        16'h0000, 8'h00, 16'h0000, 0},
            '{FR_BAD_CRC,  3,        16'h0101, 8'h20, 16'h1111, 0},
            '{FR_BAD_TAIL, 3,        16'h0202, 8'h21, 16'h2222, 0},
            '{FR_NOISE,    0,        16'h0000, 8'h00, 16'h0000, -1},
            '{FR_GOOD,     3,        16'h7fff, 8'h30, 16'h8000, 3},
            '{FR_TRUNC,    4,        16'h0303, 8'h31, 16'h3333, -1},
            '{FR_GOOD,     4,        16'h0404, 8'h32, 16'h4444, -1},
            '{FR_GOOD,     5,        16'h0505, 8'h33, 16'h5555, -1}
        };
        rst_n       = 1'b0;
        rx.valid    = 1'b0;
        rx.rx_byte  = '0;
        cfg.valid   = 1'b0;
        cfg.index   = '0;
        cfg.data    = '0;
        res.ready   = 1'b0;
        hold_res    = 1'b0;
        idle_mode   = 0;
        error_count = 0;
        units_predicted = 0;
        rd_ptr = 0;
        wr_ptr = 0;
        cfg_regs[sfr_pkg::REG_HEAD_FIRST]       = sfr_pkg::HEAD_FIRST_RST;
        cfg_regs[sfr_pkg::REG_HEAD_SECOND]      = sfr_pkg::HEAD_SECOND_RST;
        cfg_regs[sfr_pkg::REG_TAIL_LAST]        = sfr_pkg::TAIL_LAST_RST;
        cfg_regs[sfr_pkg::REG_TAIL_BEFORE_LAST] = sfr_pkg::TAIL_BEFORE_LAST_RST;
        cfg_regs[sfr_pkg::REG_KNOWN_CODE_COUNT] = sfr_pkg::KNOWN_CODE_COUNT_RST;
        repeat (11)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (rows[i])
        begin
            units_before = units_predicted;
            send_frame(rows[i].kind, rows[i].units, rows[i].serial, 1'b1,
                       rows[i].code, rows[i].value);
            if (rows[i].exp_units >= 0 &&
                units_predicted - units_before != rows[i].exp_units)
                report($sformatf("row %0d gives %0d units, want %0d", i,
                                 units_predicted - units_before, rows[i].exp_units));
        end
        drain();

        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                1:
                begin
                    write_reg(sfr_pkg::REG_HEAD_FIRST, 8'h00);
                    write_reg(sfr_pkg::REG_HEAD_SECOND, 8'hff);
                    write_reg(sfr_pkg::REG_TAIL_LAST, 8'h00);
                    write_reg(sfr_pkg::REG_TAIL_BEFORE_LAST, 8'hff);
                    write_reg(sfr_pkg::REG_KNOWN_CODE_COUNT, 8'h00);
                end
                2:
                begin
                    write_reg(sfr_pkg::REG_HEAD_FIRST, 8'hff);
                    write_reg(sfr_pkg::REG_HEAD_SECOND, 8'h00);
                    write_reg(sfr_pkg::REG_TAIL_LAST, 8'hff);
                    write_reg(sfr_pkg::REG_TAIL_BEFORE_LAST, 8'h00);
                    write_reg(sfr_pkg::REG_KNOWN_CODE_COUNT, 8'hff);
                end
                3, 4:
                begin
                    for (int r = 0; r < 5; r++)
                        write_reg(r[sfr_pkg::CFG_IDX_W-1:0],
                                  sfr_pkg::BYTE_W'($urandom_range(255)));
                end
                default:
                begin
                end
            endcase
            idle_mode = ph % 4;
            if (ph == 1)
            begin
                // Long stall on results while bytes keep coming, so the input backs up.
                fork
                    begin
                        hold_res = 1'b1;
                        repeat (600)
                            @(posedge clk);
                        hold_res = 1'b0;
                    end
                join_none
            end
            random_traffic(50);
            drain();
        end

        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
